/* sv/htl_pkg.sv */
package htl_pkg;

   // field widths fixed by the interface
   localparam int TEMP_W     = 12;
   localparam int TARGET_W   = 9;
   localparam int HYST_W     = 7;
   localparam int MIN_SW_W   = 22;
   localparam int READ_IV_W  = 20;
   localparam int NOW_W      = 32;
   localparam int CSR_DATA_W = 22;
   localparam int CSR_IDX_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TEMP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS_BAND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_HIGH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SWITCH      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_INTERVAL   = 3'd4;

   // opcodes
   localparam logic [1:0] OP_SAMPLE      = 2'd0;
   localparam logic [1:0] OP_FORCE_OFF   = 2'd1;
   localparam logic [1:0] OP_STATS_RESET = 2'd2;

   // clamp limits and reset values; temperatures in 1/16 degree units, times in ms
   localparam logic [TARGET_W-1:0]  TARGET_MIN   = 9'd288;
   localparam logic [TARGET_W-1:0]  TARGET_MAX   = 9'd480;
   localparam logic [TARGET_W-1:0]  TARGET_RST   = 9'd400;
   localparam logic [HYST_W-1:0]    HYST_MIN     = 7'd2;
   localparam logic [HYST_W-1:0]    HYST_MAX     = 7'd80;
   localparam logic [HYST_W-1:0]    HYST_RST     = 7'd8;
   localparam logic [MIN_SW_W-1:0]  MIN_SW_RST   = 22'd60000;
   localparam logic [READ_IV_W-1:0] READ_IV_RST  = 20'd1000;

   localparam logic signed [TEMP_W-1:0] DISCONNECT_CODE = -12'sd2032;
   localparam logic signed [TEMP_W-1:0] T85             = 12'sd1360;
   localparam logic signed [TEMP_W-1:0] T_LOW_EXCL      = -12'sd800;
   localparam logic signed [TEMP_W-1:0] T_HIGH_EXCL     = 12'sd800;
   localparam logic signed [TEMP_W-1:0] STAT_MIN_RST    = 12'sd1600;
   localparam logic signed [TEMP_W-1:0] STAT_MAX_RST    = -12'sd1600;

   typedef struct packed {
      logic [TARGET_W-1:0]  target_temp;
      logic [HYST_W-1:0]    hysteresis_band;
      logic                 heater_active_high;
      logic [MIN_SW_W-1:0]  switch_lockout_ms;
      logic [READ_IV_W-1:0] read_interval;
   } htl_cfg_type;

   typedef struct packed {
      logic [1:0]               opcode;
      logic [NOW_W-1:0]         now_ms;
      logic signed [TEMP_W-1:0] temp_sample;
      logic                     sensor_present;
   } htl_item_type;

   typedef struct packed {
      logic                     heater_level;
      logic                     heater_on;
      logic signed [TEMP_W-1:0] reported_temp;
      logic                     reported_valid;
      logic signed [TEMP_W-1:0] daily_min;
      logic signed [TEMP_W-1:0] daily_max;
      logic                     sample_accepted;
   } htl_result_type;

endpackage

/* sv/htl_csr.sv */
module htl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [htl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [htl_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output htl_pkg::htl_cfg_type                cfg
);
   import htl_pkg::*;

   htl_cfg_type          cfg_ff, cfg_in;
   logic [TARGET_W-1:0]  tgt_raw;
   logic [HYST_W-1:0]    hyst_raw;

   assign tgt_raw  = csr_wdata[TARGET_W-1:0];
   assign hyst_raw = csr_wdata[HYST_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_TARGET_TEMP: begin
               // clamp into the allowed setpoint range
               if (tgt_raw < TARGET_MIN)      cfg_in.target_temp = TARGET_MIN;
               else if (tgt_raw > TARGET_MAX) cfg_in.target_temp = TARGET_MAX;
               else                           cfg_in.target_temp = tgt_raw;
            end
            CSR_HYSTERESIS_BAND: begin
               if (hyst_raw < HYST_MIN)      cfg_in.hysteresis_band = HYST_MIN;
               else if (hyst_raw > HYST_MAX) cfg_in.hysteresis_band = HYST_MAX;
               else                          cfg_in.hysteresis_band = hyst_raw;
            end
            CSR_ACTIVE_HIGH:   cfg_in.heater_active_high  = csr_wdata[0];
            CSR_MIN_SWITCH:    cfg_in.switch_lockout_ms   = csr_wdata[MIN_SW_W-1:0];
            CSR_READ_INTERVAL: cfg_in.read_interval       = csr_wdata[READ_IV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_temp         <= TARGET_RST;
         cfg_ff.hysteresis_band     <= HYST_RST;
         cfg_ff.heater_active_high  <= 1'b1;
         cfg_ff.switch_lockout_ms   <= MIN_SW_RST;
         cfg_ff.read_interval       <= READ_IV_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/htl_core.sv */
module htl_core #(
   parameter int TIME_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  htl_pkg::htl_item_type   item,
   input  htl_pkg::htl_cfg_type    cfg,
   output htl_pkg::htl_result_type result
);
   import htl_pkg::*;

   localparam int CMP_W = (TIME_BITS > MIN_SW_W) ? TIME_BITS : MIN_SW_W;

   logic                     heater_ff, heater_in;
   logic [TIME_BITS-1:0]     switch_time_ff, switch_time_in;
   logic                     switch_free_ff, switch_free_in;
   logic [TIME_BITS-1:0]     read_time_ff, read_time_in;
   logic signed [TEMP_W-1:0] held_ff, held_in;
   logic                     held_valid_ff, held_valid_in;
   logic signed [TEMP_W-1:0] day_min_ff, day_min_in;
   logic signed [TEMP_W-1:0] day_max_ff, day_max_in;

   logic [TIME_BITS-1:0]     now_t;
   logic [TIME_BITS-1:0]     read_diff, switch_diff;
   logic                     read_due, switch_ok;
   logic                     take, good, in_range;
   logic signed [TEMP_W:0]   held_x, tgt_x, low_x;
   logic                     want_sw, do_sw;
   logic signed [TEMP_W-1:0] smp;

   assign smp         = item.temp_sample;
   assign now_t       = TIME_BITS'(item.now_ms);
   assign read_diff   = now_t - read_time_ff;
   assign switch_diff = now_t - switch_time_ff;
   assign read_due    = CMP_W'(read_diff) >= CMP_W'(cfg.read_interval);
   assign switch_ok   = switch_free_ff ||
                        (CMP_W'(switch_diff) >= CMP_W'(cfg.switch_lockout_ms));

   assign in_range = (smp != DISCONNECT_CODE) && (smp != T85) &&
                     (smp > T_LOW_EXCL) && (smp < T_HIGH_EXCL);
   assign take     = (item.opcode == OP_SAMPLE) && read_due;
   assign good     = take && item.sensor_present && in_range;

   assign held_in       = good ? smp : held_ff;
   assign held_valid_in = held_valid_ff | good;
   assign read_time_in  = take ? now_t : read_time_ff;

   always_comb begin
      day_min_in = day_min_ff;
      day_max_in = day_max_ff;
      if (item.opcode == OP_STATS_RESET) begin
         day_min_in = smp;
         day_max_in = smp;
      end else if (good) begin
         if (smp < day_min_ff) day_min_in = smp;
         if (smp > day_max_ff) day_max_in = smp;
      end
   end

   // regulate from the freshly updated held temperature
   assign held_x = {held_in[TEMP_W-1], held_in};
   assign tgt_x  = $signed({{(TEMP_W + 1 - TARGET_W){1'b0}}, cfg.target_temp});
   assign low_x  = tgt_x - $signed({{(TEMP_W + 1 - HYST_W){1'b0}}, cfg.hysteresis_band});

   assign want_sw = held_valid_in &&
                    ((heater_ff && (held_x >= tgt_x)) || (!heater_ff && (held_x <= low_x)));
   assign do_sw   = (item.opcode == OP_FORCE_OFF) ||
                    ((item.opcode == OP_SAMPLE) && want_sw && switch_ok);

   assign heater_in      = (item.opcode == OP_FORCE_OFF) ? 1'b0 :
                           (do_sw ? !heater_ff : heater_ff);
   assign switch_time_in = do_sw ? now_t : switch_time_ff;
   assign switch_free_in = switch_free_ff & ~do_sw;

   always_ff @(posedge clock) begin
      if (reset) begin
         heater_ff      <= 1'b1;
         switch_time_ff <= '0;
         switch_free_ff <= 1'b1;
         read_time_ff   <= '0;
         held_ff        <= '0;
         held_valid_ff  <= 1'b0;
         day_min_ff     <= STAT_MIN_RST;
         day_max_ff     <= STAT_MAX_RST;
      end else if (step) begin
         heater_ff      <= heater_in;
         switch_time_ff <= switch_time_in;
         switch_free_ff <= switch_free_in;
         read_time_ff   <= read_time_in;
         held_ff        <= held_in;
         held_valid_ff  <= held_valid_in;
         day_min_ff     <= day_min_in;
         day_max_ff     <= day_max_in;
      end
   end

   assign result.heater_level    = ~(heater_in ^ cfg.heater_active_high);
   assign result.heater_on       = heater_in;
   assign result.reported_temp   = held_valid_in ? held_in : DISCONNECT_CODE;
   assign result.reported_valid  = held_valid_in;
   assign result.daily_min       = day_min_in;
   assign result.daily_max       = day_max_in;
   assign result.sample_accepted = good;

endmodule

/* sv/hysteresis_thermostat_lockout.sv */
// A beat accepted on req_ is held in the input register, then offered on rsp_ from the result register.
// Throughput: one beat per cycle while rsp_ is not stalled; the state update is a
//   compare-and-update loop between the input register and the result register.
// A stalled rsp_ holds its beat and backs the input register up into req_stall.
// Reset (synchronous, active high) loads the register defaults, heater on with
//   the first switch free, no held temperature and empty daily statistics.
module hysteresis_thermostat_lockout #(
   parameter int TIME_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_opcode,
   input  logic [htl_pkg::NOW_W-1:0]         req_now_ms,
   input  logic signed [htl_pkg::TEMP_W-1:0] req_temp_sample,
   input  logic                              req_sensor_present,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_heater_level,
   output logic                              rsp_heater_on,
   output logic signed [htl_pkg::TEMP_W-1:0] rsp_reported_temp,
   output logic                              rsp_reported_valid,
   output logic signed [htl_pkg::TEMP_W-1:0] rsp_daily_min,
   output logic signed [htl_pkg::TEMP_W-1:0] rsp_daily_max,
   output logic                              rsp_sample_accepted,

   input  logic                              csr_wen,
   input  logic [htl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [htl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import htl_pkg::*;

   htl_cfg_type    cfg;
   htl_item_type   item_ff, item_in;
   logic           item_valid_ff, item_valid_in;
   htl_result_type res_ff, res_comb;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           req_take;    // input beat accepted this cycle
   logic           rsp_open;    // result register can load
   logic           advance;     // input register retires into the result register

   htl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   htl_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (res_comb)
   );

   // The result register frees up when empty or when its beat leaves this cycle,
   // so a held result never blocks the input side longer than the stall itself.
   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = item_valid_ff && rsp_open;
   assign req_stall = item_valid_ff && !rsp_open;
   assign req_take  = req_valid && !req_stall;

   assign item_in.opcode         = req_opcode;
   assign item_in.now_ms         = req_now_ms;
   assign item_in.temp_sample    = req_temp_sample;
   assign item_in.sensor_present = req_sensor_present;

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload: load the input beat on accept, the result on advance; hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= res_comb;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_heater_level    = res_ff.heater_level;
   assign rsp_heater_on       = res_ff.heater_on;
   assign rsp_reported_temp   = res_ff.reported_temp;
   assign rsp_reported_valid  = res_ff.reported_valid;
   assign rsp_daily_min       = res_ff.daily_min;
   assign rsp_daily_max       = res_ff.daily_max;
   assign rsp_sample_accepted = res_ff.sample_accepted;

`ifndef SYNTHESIS
   // an input beat waiting for the result register is never dropped
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> item_valid_ff)
      else $error("input beat lost while waiting");

   // stall the input side only while a beat sits in the input register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("req_stall without a blocked beat");

   // without any held reading, report the disconnect code and no acceptance
   a_no_reading: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reported_valid) |->
         (rsp_reported_temp == DISCONNECT_CODE && !rsp_sample_accepted))
      else $error("reported temperature without a valid reading");

   // a freshly accepted reading lies within the daily min and max
   a_stats_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sample_accepted) |->
         (rsp_reported_valid && rsp_daily_min <= rsp_reported_temp &&
          rsp_reported_temp <= rsp_daily_max))
      else $error("accepted reading outside daily statistics");
`endif

endmodule

/* test/hysteresis_thermostat_lockout_test.sv */
module hysteresis_thermostat_lockout_test;
   timeunit 1ns;
   timeprecision 1ps;

   import htl_pkg::*;

   // Opcode 3 is not decoded by the block; it must leave all state alone.
   localparam logic [1:0]           OP_UNUSED     = 2'd3;
   // Index past the last register; writes to it must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE     = 3'd7;
   localparam int                   CYCLE_LIMIT   = 400000;
   localparam int                   RANDOM_BEATS  = 250;
   localparam int                   SETTING_COUNT = 6;

   // Status expected before any valid reading: heater on, no held value,
   // daily statistics at their empty marks.
   localparam htl_result_type NO_READING =
      '{1'b1, 1'b1, DISCONNECT_CODE, 1'b0, STAT_MIN_RST, STAT_MAX_RST, 1'b0};

   typedef struct packed {
      htl_item_type   beat;
      logic           typed;    // 1: status below is the answer, 0: predict it
      htl_result_type status;
   } plan_row_type;

   logic                     clock              = 1'b0;
   logic                     reset              = 1'b1;
   logic                     req_valid          = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_opcode         = OP_SAMPLE;
   logic [NOW_W-1:0]         req_now_ms         = '0;
   logic signed [TEMP_W-1:0] req_temp_sample    = '0;
   logic                     req_sensor_present = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall          = 1'b0;
   logic                     rsp_heater_level;
   logic                     rsp_heater_on;
   logic signed [TEMP_W-1:0] rsp_reported_temp;
   logic                     rsp_reported_valid;
   logic signed [TEMP_W-1:0] rsp_daily_min;
   logic signed [TEMP_W-1:0] rsp_daily_max;
   logic                     rsp_sample_accepted;
   logic                     csr_wen            = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index          = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata          = '0;

   // Predictor copy of the registers and the thermostat state.
   htl_cfg_type            setting;
   logic                   heat_cmd;
   logic                   first_switch_free;
   logic [NOW_W-1:0]       switch_ms;
   logic [NOW_W-1:0]       read_ms;
   logic signed [TEMP_W:0] held_temp;
   logic                   held_ok;
   logic signed [TEMP_W:0] low_mark;
   logic signed [TEMP_W:0] high_mark;

   htl_result_type status_due [$];   // status beats still owed by the block
   int             send_idle_pct;
   int             stall_pct;
   int             fault_count = 0;
   int             cycle_count = 0;

   // Directed walk under the reset settings: target 400, band 8, active high,
   // 60000 ms lockout, 1000 ms read interval.
   plan_row_type plan [20] = '{
      // unused opcode: nothing moves
      '{'{OP_UNUSED, 32'd0, 12'sd0, 1'b1}, 1'b1, NO_READING},
      // read interval not yet elapsed
      '{'{OP_SAMPLE, 32'd500, 12'sd100, 1'b1}, 1'b1, NO_READING},
      // sensor absent: read time advances, no reading
      '{'{OP_SAMPLE, 32'd1000, 12'sd100, 1'b0}, 1'b1, NO_READING},
      // invalid readings: disconnect code, 85 degrees, range edges, extremes
      '{'{OP_SAMPLE, 32'd2000, DISCONNECT_CODE, 1'b1}, 1'b1, NO_READING},
      '{'{OP_SAMPLE, 32'd3000, T85, 1'b1}, 1'b1, NO_READING},
      '{'{OP_SAMPLE, 32'd4000, T_HIGH_EXCL, 1'b1}, 1'b1, NO_READING},
      '{'{OP_SAMPLE, 32'd5000, T_LOW_EXCL, 1'b1}, 1'b1, NO_READING},
      '{'{OP_SAMPLE, 32'd6000, -12'sd2048, 1'b1}, 1'b1, NO_READING},
      '{'{OP_SAMPLE, 32'd7000, 12'sd2047, 1'b1}, 1'b1, NO_READING},
      // first valid reading above target: free first switch turns heat off
      '{'{OP_SAMPLE, 32'd8000, 12'sd799, 1'b1}, 1'b1,
        '{1'b0, 1'b0, 12'sd799, 1'b1, 12'sd799, 12'sd799, 1'b1}},
      // cold reading inside the lockout: heater stays off
      '{'{OP_SAMPLE, 32'd9000, -12'sd799, 1'b1}, 1'b1,
        '{1'b0, 1'b0, -12'sd799, 1'b1, -12'sd799, 12'sd799, 1'b1}},
      // exactly target minus band, exactly at the lockout boundary
      '{'{OP_SAMPLE, 32'd68000, 12'sd392, 1'b1}, 1'b0, '0},
      // force off inside the lockout
      '{'{OP_FORCE_OFF, 32'd68100, 12'sd0, 1'b0}, 1'b1,
        '{1'b0, 1'b0, 12'sd392, 1'b1, -12'sd799, 12'sd799, 1'b0}},
      // stats reset takes the raw sample, extremes included
      '{'{OP_STATS_RESET, 32'd68200, -12'sd2048, 1'b0}, 1'b1,
        '{1'b0, 1'b0, 12'sd392, 1'b1, -12'sd2048, -12'sd2048, 1'b0}},
      '{'{OP_STATS_RESET, 32'd68300, 12'sd2047, 1'b1}, 1'b1,
        '{1'b0, 1'b0, 12'sd392, 1'b1, 12'sd2047, 12'sd2047, 1'b0}},
      // timestamps across the wrap point
      '{'{OP_SAMPLE, 32'hFFFF_FFFF, 12'sd400, 1'b1}, 1'b0, '0},
      '{'{OP_SAMPLE, 32'd999, 12'sd300, 1'b1}, 1'b0, '0},
      '{'{OP_FORCE_OFF, 32'hFFFF_FFFF, -12'sd1, 1'b0}, 1'b0, '0},
      '{'{OP_UNUSED, 32'hFFFF_FFFF, -12'sd1, 1'b1}, 1'b0, '0},
      '{'{OP_SAMPLE, 32'h8000_0000, 12'sd0, 1'b1}, 1'b0, '0}
   };

   hysteresis_thermostat_lockout i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_now_ms          (req_now_ms),
      .req_temp_sample     (req_temp_sample),
      .req_sensor_present  (req_sensor_present),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_heater_level    (rsp_heater_level),
      .rsp_heater_on       (rsp_heater_on),
      .rsp_reported_temp   (rsp_reported_temp),
      .rsp_reported_valid  (rsp_reported_valid),
      .rsp_daily_min       (rsp_daily_min),
      .rsp_daily_max       (rsp_daily_max),
      .rsp_sample_accepted (rsp_sample_accepted),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Record a heater switch event; it also ends the free first switch.
   function automatic void log_switch(input logic turn_on, input logic [NOW_W-1:0] now);
      heat_cmd          = turn_on;
      switch_ms         = now;
      first_switch_free = 1'b0;
   endfunction

   // Advance the thermostat by one beat and return the status it reports.
   function automatic htl_result_type thermostat_step(input htl_item_type beat);
      htl_result_type         status;
      logic [NOW_W-1:0]       since_read;
      logic [NOW_W-1:0]       since_switch;
      logic signed [TEMP_W:0] reading;
      logic                   took;
      logic                   may_switch;
      int                     target;

      reading      = beat.temp_sample;
      took         = 1'b0;
      since_read   = beat.now_ms - read_ms;
      since_switch = beat.now_ms - switch_ms;
      may_switch   = first_switch_free || since_switch >= NOW_W'(setting.switch_lockout_ms);
      target       = int'(setting.target_temp);

      case (beat.opcode)
         OP_SAMPLE: begin
            if (since_read >= NOW_W'(setting.read_interval)) begin
               read_ms = beat.now_ms;
               if (beat.sensor_present && beat.temp_sample != DISCONNECT_CODE &&
                   beat.temp_sample != T85 && beat.temp_sample > T_LOW_EXCL &&
                   beat.temp_sample < T_HIGH_EXCL) begin
                  held_temp = reading;
                  held_ok   = 1'b1;
                  took      = 1'b1;
                  if (reading < low_mark) low_mark = reading;
                  if (reading > high_mark) high_mark = reading;
               end
            end
            // regulate from the held value; lockout postpones the switch
            if (held_ok) begin
               if (heat_cmd && int'(held_temp) >= target) begin
                  if (may_switch) log_switch(1'b0, beat.now_ms);
               end else if (!heat_cmd &&
                            int'(held_temp) <= target - int'(setting.hysteresis_band)) begin
                  if (may_switch) log_switch(1'b1, beat.now_ms);
               end
            end
         end
         OP_FORCE_OFF: log_switch(1'b0, beat.now_ms);
         OP_STATS_RESET: begin
            low_mark  = reading;
            high_mark = reading;
         end
         default: ;
      endcase

      status.heater_level    = (heat_cmd == setting.heater_active_high);
      status.heater_on       = heat_cmd;
      status.reported_temp   = held_ok ? held_temp[TEMP_W-1:0] : DISCONNECT_CODE;
      status.reported_valid  = held_ok;
      status.daily_min       = low_mark[TEMP_W-1:0];
      status.daily_max       = high_mark[TEMP_W-1:0];
      status.sample_accepted = took;
      return status;
   endfunction

   // Offer one beat, hold it until accepted, then queue its status.
   task automatic push_beat(input htl_item_type beat, input logic typed,
                            input htl_result_type typed_status);
      htl_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= beat.opcode;
      req_now_ms         <= beat.now_ms;
      req_temp_sample    <= beat.temp_sample;
      req_sensor_present <= beat.sensor_present;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = thermostat_step(beat);
      status_due.push_back(typed ? typed_status : predicted);
   endtask

   // Drop valid and hold off until every owed status beat has come back.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (status_due.size() != 0) @(posedge clock);
   endtask

   // Write one register and mirror the clamping into the predictor.
   // Leaves csr_wen high so back-to-back writes need no toggle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] slot,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= slot;
      csr_wdata <= data;
      @(posedge clock);
      case (slot)
         CSR_TARGET_TEMP:
            setting.target_temp = (data[TARGET_W-1:0] < TARGET_MIN) ? TARGET_MIN :
                                  (data[TARGET_W-1:0] > TARGET_MAX) ? TARGET_MAX :
                                  data[TARGET_W-1:0];
         CSR_HYSTERESIS_BAND:
            setting.hysteresis_band = (data[HYST_W-1:0] < HYST_MIN) ? HYST_MIN :
                                      (data[HYST_W-1:0] > HYST_MAX) ? HYST_MAX :
                                      data[HYST_W-1:0];
         CSR_ACTIVE_HIGH:     setting.heater_active_high  = data[0];
         CSR_MIN_SWITCH:      setting.switch_lockout_ms   = data[MIN_SW_W-1:0];
         CSR_READ_INTERVAL:   setting.read_interval       = data[READ_IV_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] target, band, polarity,
                                input logic [CSR_DATA_W-1:0] lockout, read_gap);
      // the spare index gets noise; the block must ignore it
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom()));
      write_reg(CSR_TARGET_TEMP, target);
      write_reg(CSR_HYSTERESIS_BAND, band);
      write_reg(CSR_ACTIVE_HIGH, polarity);
      write_reg(CSR_MIN_SWITCH, lockout);
      write_reg(CSR_READ_INTERVAL, read_gap);
      csr_wen <= 1'b0;
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fault_count++;
      end
   endfunction

   // Receiver backpressure: stall at the current rate.
   always @(posedge clock) rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);

   // Status checker: match each accepted beat against the oldest expectation.
   always @(posedge clock) begin : check_status
      htl_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0) begin
            $display("%0t: status beat with nothing expected", $time);
            fault_count++;
         end else begin
            want = status_due.pop_front();
            check_field("heater_level", want.heater_level, rsp_heater_level);
            check_field("heater_on", want.heater_on, rsp_heater_on);
            check_field("reported_temp", want.reported_temp, rsp_reported_temp);
            check_field("reported_valid", want.reported_valid, rsp_reported_valid);
            check_field("daily_min", want.daily_min, rsp_daily_min);
            check_field("daily_max", want.daily_max, rsp_daily_max);
            check_field("sample_accepted", want.sample_accepted, rsp_sample_accepted);
         end
      end
   end

   // Watchdog: bail out if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d status beats owed", $time, status_due.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      htl_item_type     beat;
      logic [NOW_W-1:0] wall_ms;
      int               pick;
      int               t;

      // predictor starts from the reset state
      setting           = '{TARGET_RST, HYST_RST, 1'b1, MIN_SW_RST, READ_IV_RST};
      heat_cmd          = 1'b1;
      first_switch_free = 1'b1;
      switch_ms         = '0;
      read_ms           = '0;
      held_temp         = '0;
      held_ok           = 1'b0;
      low_mark          = STAT_MIN_RST;
      high_mark         = STAT_MAX_RST;
      send_idle_pct     = 19;
      stall_pct         = 77;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) push_beat(plan[i].beat, plan[i].typed, plan[i].status);

      wall_ms = $urandom();
      for (int seg = 0; seg < SETTING_COUNT; seg++) begin
         // registers change only with the pipe empty
         settle();
         case (seg)
            0: apply_setting(22'd400, 22'd8, 22'd1, 22'd0, 22'd0);
            1: apply_setting(22'd0, 22'd0, 22'd0, 22'h3F_FFFF, 22'h3F_FFFF);
            2: apply_setting(22'h3F_FFFF, 22'h3F_FFFF, 22'd1, 22'd100, 22'd10);
            3: apply_setting(CSR_DATA_W'($urandom_range(0, 511)),
                             CSR_DATA_W'($urandom_range(0, 127)),
                             CSR_DATA_W'($urandom_range(0, 1)),
                             CSR_DATA_W'($urandom_range(0, 5000)),
                             CSR_DATA_W'($urandom_range(0, 2000)));
            4: apply_setting(22'd288, 22'd80, 22'd0, 22'd3600000, 22'd600000);
            default: apply_setting(22'd480, 22'd2, 22'd1, 22'd1000, 22'd100);
         endcase

         // sender light and receiver heavy, then swapped, then no idling at all
         send_idle_pct = (seg < 2) ? 19 : (seg < 4) ? 77 : 0;
         stall_pct     = (seg < 2) ? 77 : (seg < 4) ? 19 : 0;

         repeat (RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            beat.opcode = (pick < 85) ? OP_SAMPLE : (pick < 90) ? OP_FORCE_OFF :
                          (pick < 95) ? OP_STATS_RESET : OP_UNUSED;

            // advance time mostly around the read interval, sometimes around
            // the lockout, now and then jump anywhere or step back
            pick = $urandom_range(0, 99);
            if (pick < 70)
               wall_ms += $urandom_range(0, 2 * setting.read_interval + 2);
            else if (pick < 90)
               wall_ms += $urandom_range(0, setting.switch_lockout_ms + 2);
            else if (pick < 95)
               wall_ms = $urandom();
            else
               wall_ms -= $urandom_range(0, 1000);
            beat.now_ms = wall_ms;

            // most readings sit around the hysteresis band to drive switching
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               t = int'(setting.target_temp) - int'(setting.hysteresis_band) - 20 +
                   int'($urandom_range(0, 40 + setting.hysteresis_band));
            end else if (pick < 85) begin
               t = int'($urandom_range(0, 4095));
            end else begin
               case ($urandom_range(0, 7))
                  0:       t = int'(DISCONNECT_CODE);
                  1:       t = int'(T85);
                  2:       t = int'(T_HIGH_EXCL);
                  3:       t = int'(T_LOW_EXCL);
                  4:       t = 799;
                  5:       t = -799;
                  6:       t = -2048;
                  default: t = 2047;
               endcase
            end
            beat.temp_sample    = t[TEMP_W-1:0];
            beat.sensor_present = ($urandom_range(0, 99) < 92);

            push_beat(beat, 1'b0, '0);
            // occasionally drain completely before the next beat
            if ($urandom_range(0, 99) < 2) settle();
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (fault_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
